@@ hdl/hsgd_pkg.sv @@
package hsgd_pkg;

  localparam int unsigned HistoryDepthDefault = 64;
  localparam int unsigned CoordBitsDefault    = 16;
  localparam int unsigned WindowStepDefault   = 100;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegMinSwipe   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegMaxHeight  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegMaxDev     = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegBackStep   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegStillTol   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegHoldOff    = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegWinLongest = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegWinShort   = 3'd7;

  // gesture codes
  localparam logic [1:0] GestNone  = 2'd0;
  localparam logic [1:0] GestLeft  = 2'd1;
  localparam logic [1:0] GestRight = 2'd2;

  typedef struct packed {
    logic [14:0] min_swipe_length;
    logic [14:0] max_height_change;
    logic [14:0] max_dev_from_mean;
    logic [14:0] back_step_tolerance;
    logic [14:0] still_tolerance;
    logic [15:0] hold_off_ms;
    logic [15:0] window_longest_ms;
    logic [15:0] window_shortest_ms;
  } cfg_t;

endpackage

@@ hdl/hsgd_if.sv @@
interface hsgd_in_if #(
  parameter int unsigned CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic [31:0]                 now_ms;
  logic signed [CoordBits-1:0] hip_x;
  logic signed [CoordBits-1:0] hip_y;
  logic signed [CoordBits-1:0] hip_z;
  logic signed [CoordBits-1:0] shoulder_y;
  logic signed [CoordBits-1:0] left_hand_x;
  logic signed [CoordBits-1:0] left_hand_y;
  logic signed [CoordBits-1:0] right_hand_x;
  logic signed [CoordBits-1:0] right_hand_y;

  modport source (output valid, now_ms, hip_x, hip_y, hip_z, shoulder_y,
                  left_hand_x, left_hand_y, right_hand_x, right_hand_y,
                  input ready);
  modport sink (input valid, now_ms, hip_x, hip_y, hip_z, shoulder_y,
                left_hand_x, left_hand_y, right_hand_x, right_hand_y,
                output ready);
endinterface

interface hsgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;
  logic       standing;
  logic       suppressed;

  modport source (output valid, gesture, standing, suppressed, input ready);
  modport sink (input valid, gesture, standing, suppressed, output ready);
endinterface

@@ hdl/hsgd_cfg_regs.sv @@
module hsgd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hsgd_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [hsgd_pkg::CfgDataBits-1:0]  cfg_data_i,
  output hsgd_pkg::cfg_t                    cfg_o
);
  import hsgd_pkg::*;

  cfg_t cfg_q;

  // register file with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_swipe_length    <= 15'd2048;
      cfg_q.max_height_change   <= 15'd1024;
      cfg_q.max_dev_from_mean   <= 15'd819;
      cfg_q.back_step_tolerance <= 15'd123;
      cfg_q.still_tolerance     <= 15'd205;
      cfg_q.hold_off_ms         <= 16'd1500;
      cfg_q.window_longest_ms   <= 16'd1000;
      cfg_q.window_shortest_ms  <= 16'd500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinSwipe:   cfg_q.min_swipe_length    <= cfg_data_i[14:0];
        RegMaxHeight:  cfg_q.max_height_change   <= cfg_data_i[14:0];
        RegMaxDev:     cfg_q.max_dev_from_mean   <= cfg_data_i[14:0];
        RegBackStep:   cfg_q.back_step_tolerance <= cfg_data_i[14:0];
        RegStillTol:   cfg_q.still_tolerance     <= cfg_data_i[14:0];
        RegHoldOff:    cfg_q.hold_off_ms         <= cfg_data_i;
        RegWinLongest: cfg_q.window_longest_ms   <= cfg_data_i;
        RegWinShort:   cfg_q.window_shortest_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

@@ hdl/hand_swipe_gesture_detector_unit.sv @@
// hand swipe gesture detector
//
// in_if carries one skeleton frame per word (valid/ready); out_if returns
// exactly one result word per frame: gesture, standing and suppressed.
// cfg_we_i/cfg_idx_i/cfg_data_i write the eight thresholds; write only while
// idle.
//
// Each hand keeps a circular history in a memory of HISTORY_DEPTH entries.
// One frame is processed by a sequencer around a single shared datapath
// that reads at most one history entry per cycle. Per hand: one pass drops
// stale points, then for each sub-window one pass finds the first and last
// selected point and a second pass checks monotonicity and deviation.
// At most six sub-windows are tried per hand with the default thresholds,
// up to 656 with the default window step; each history holds up to
// HISTORY_DEPTH points. A new frame is taken the cycle after the result
// word leaves; a stalled receiver simply holds the result, nothing is lost.
// Reset empties both histories, clears the hip reference and hold-off, and
// loads the default thresholds; no clearing pass is needed.
module hand_swipe_gesture_detector_unit #(
  parameter int unsigned HISTORY_DEPTH  = hsgd_pkg::HistoryDepthDefault,
  parameter int unsigned COORD_BITS     = hsgd_pkg::CoordBitsDefault,
  parameter int unsigned WINDOW_STEP_MS = hsgd_pkg::WindowStepDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsgd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [hsgd_pkg::CfgDataBits-1:0] cfg_data_i,
  hsgd_in_if.sink                          in_if,
  hsgd_out_if.source                       out_if
);
  import hsgd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned VW = COORD_BITS + 3;
  localparam logic [CW-1:0] DepthC = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(HISTORY_DEPTH - 1);
  localparam logic [17:0] StepC    = 18'(WINDOW_STEP_MS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HIP   = 4'd1;
  localparam logic [3:0] S_PUSH  = 4'd2;
  localparam logic [3:0] S_TRIM  = 4'd3;
  localparam logic [3:0] S_WIN   = 4'd4;
  localparam logic [3:0] S_SCAN1 = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_SCAN2 = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_HAND  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  cfg_t cfg;

  hsgd_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // frame registers
  logic [31:0]                 now_q;
  logic signed [COORD_BITS-1:0] hx_q, hy_q, hz_q, sh_q, lx_q, ly_q, rx_q, ry_q;
  logic signed [COORD_BITS-1:0] ref_x_q, ref_y_q, ref_z_q;
  logic                        ref_v_q;
  logic [31:0]                 hold_until_q;
  logic                        hold_q;

  logic [3:0]    st_q;
  logic          hand_q;      // 0 left, 1 right
  logic [AW-1:0] head_q [2];  // oldest entry
  logic [CW-1:0] cnt_q [2];
  logic [CW-1:0] idx_q;       // scan position, relative to head
  logic [17:0]   span_q;      // signed span, 18 bits
  logic          found_q, ok_q, first_q;
  logic [CW-1:0] f_q, e_q;    // relative positions of first / last
  logic signed [COORD_BITS-1:0] fx_q, fy_q, ex_q, ey_q, px_q;
  logic [1:0]    gest_q;
  logic          stand_q, supp_q, ovalid_q;

  // history memories, one word per entry {time, y, x}
  localparam int unsigned MW = 32 + 2 * COORD_BITS;
  logic [MW-1:0] mem_l [HISTORY_DEPTH];
  logic [MW-1:0] mem_r [HISTORY_DEPTH];
  logic [MW-1:0] rd_l_q, rd_r_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata;
  logic          rd_v_q;      // read data valid, for position rd_pos_q
  logic [CW-1:0] rd_pos_q;

  always_ff @(posedge clk_i) begin
    if (we && !hand_q) mem_l[waddr] <= wdata;
    if (we && hand_q)  mem_r[waddr] <= wdata;
    rd_l_q <= mem_l[raddr];
    rd_r_q <= mem_r[raddr];
  end

  logic [MW-1:0] rd;
  assign rd = hand_q ? rd_r_q : rd_l_q;
  logic [31:0] rd_t;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  assign rd_t = rd[MW-1 -: 32];
  assign rd_y = rd[2*COORD_BITS-1 -: COORD_BITS];
  assign rd_x = rd[COORD_BITS-1:0];

  // shared datapath
  logic [31:0] age;
  logic        in_span, too_old;
  assign age     = now_q - rd_t;
  assign in_span = age <= {14'd0, span_q};
  assign too_old = age > {16'd0, cfg.window_longest_ms};

  logic signed [VW-1:0] sum2, hip2, sh2;
  assign sum2 = VW'(fy_q) + VW'(ey_q);
  assign hip2 = VW'(hy_q) <<< 1;
  assign sh2  = VW'(sh_q) <<< 1;

  logic signed [VW-1:0] travel, hchg, back, dev2;
  assign travel = hand_q ? VW'(fx_q) - VW'(ex_q) : VW'(ex_q) - VW'(fx_q);
  assign hchg   = VW'(ey_q) - VW'(fy_q);
  assign back   = hand_q ? VW'(rd_x) - VW'(px_q) : VW'(px_q) - VW'(rd_x);
  assign dev2   = (VW'(rd_y) <<< 1) - sum2;

  logic [VW-1:0] hchg_abs, dev_abs;
  assign hchg_abs = hchg[VW-1] ? -hchg : hchg;
  assign dev_abs  = dev2[VW-1] ? -dev2 : dev2;

  // hip compare
  logic signed [VW-1:0] dx, dy, dz;
  logic signed [COORD_BITS-1:0] rfx, rfy, rfz;
  assign rfx = ref_v_q ? ref_x_q : hx_q;
  assign rfy = ref_v_q ? ref_y_q : hy_q;
  assign rfz = ref_v_q ? ref_z_q : hz_q;
  assign dx = VW'(rfx) - VW'(hx_q);
  assign dy = VW'(rfy) - VW'(hy_q);
  assign dz = VW'(rfz) - VW'(hz_q);
  logic [VW-1:0] adx, ady, adz;
  assign adx = dx[VW-1] ? -dx : dx;
  assign ady = dy[VW-1] ? -dy : dy;
  assign adz = dz[VW-1] ? -dz : dz;
  logic still;
  assign still = adx <= VW'(cfg.still_tolerance) && ady <= VW'(cfg.still_tolerance)
              && adz <= VW'(cfg.still_tolerance);

  logic [AW-1:0] cur_head;
  logic [CW-1:0] cur_cnt;
  assign cur_head = head_q[hand_q];
  assign cur_cnt  = cnt_q[hand_q];

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, CW'(a)} + {1'b0, b};
    if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [CW-1:0] full_cnt;
  assign full_cnt = (cur_cnt == DepthC) ? cur_cnt - CW'(1) : cur_cnt;

  // write port: append at head + count
  assign we    = st_q == S_PUSH;
  assign waddr = wrap_add((cur_cnt == DepthC) ? ((cur_head == LastA) ? '0 : cur_head + 1'b1)
                          : cur_head, full_cnt);
  assign wdata = hand_q ? {now_q, ry_q, rx_q} : {now_q, ly_q, lx_q};
  assign raddr = wrap_add(cur_head, (idx_q == DepthC) ? '0 : idx_q);

  assign in_if.ready  = st_q == S_IDLE && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.gesture    = gest_q;
  assign out_if.standing   = stand_q;
  assign out_if.suppressed = supp_q;

  logic [31:0] hold_diff;
  assign hold_diff = in_if.now_ms - hold_until_q;

  logic win_ok;
  assign win_ok = !span_q[17] && span_q[16:0] >= {1'b0, cfg.window_shortest_ms};

  // read issue: trim alternates issue and decide, scans stream the range
  logic rd_req;
  assign rd_req = (st_q == S_TRIM && !rd_v_q)
               || (st_q == S_SCAN1 && idx_q != cur_cnt)
               || (st_q == S_SCAN2 && idx_q != e_q + CW'(1));

  // read data tracking, valid the cycle after issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; rd_pos_q <= '0;
    end else begin
      rd_v_q   <= rd_req;
      rd_pos_q <= idx_q;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; hand_q <= 1'b0; ovalid_q <= 1'b0;
      head_q[0] <= '0; head_q[1] <= '0; cnt_q[0] <= '0; cnt_q[1] <= '0;
      ref_v_q <= 1'b0; hold_q <= 1'b0; hold_until_q <= '0;
      ref_x_q <= '0; ref_y_q <= '0; ref_z_q <= '0;
      idx_q <= '0;
    end else begin
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            now_q <= in_if.now_ms;
            hx_q <= in_if.hip_x; hy_q <= in_if.hip_y; hz_q <= in_if.hip_z;
            sh_q <= in_if.shoulder_y;
            lx_q <= in_if.left_hand_x;  ly_q <= in_if.left_hand_y;
            rx_q <= in_if.right_hand_x; ry_q <= in_if.right_hand_y;
            gest_q <= GestNone; supp_q <= 1'b0; stand_q <= 1'b0;
            if (hold_q && hold_diff[31]) begin
              supp_q <= 1'b1;
              st_q   <= S_OUT;
            end else begin
              hold_q <= 1'b0;
              st_q   <= S_HIP;
            end
          end
        end
        S_HIP: begin
          stand_q <= still;
          ref_v_q <= 1'b1;
          hand_q  <= 1'b0;
          if (!still || !ref_v_q) begin
            ref_x_q <= hx_q; ref_y_q <= hy_q; ref_z_q <= hz_q;
          end
          if (!still) begin
            cnt_q[0] <= '0; cnt_q[1] <= '0;
            st_q <= S_OUT;
          end else st_q <= S_PUSH;
        end
        S_PUSH: begin
          if (cur_cnt == DepthC) head_q[hand_q] <= (cur_head == LastA) ? '0 : cur_head + 1'b1;
          cnt_q[hand_q] <= full_cnt + CW'(1);
          idx_q <= '0;
          st_q  <= S_TRIM;
        end
        S_TRIM: begin
          // check oldest entry; read issued this cycle, data next
          if (rd_v_q) begin
            if (cur_cnt != '0 && too_old) begin
              head_q[hand_q] <= (cur_head == LastA) ? '0 : cur_head + 1'b1;
              cnt_q[hand_q]  <= cur_cnt - CW'(1);
            end else begin
              span_q <= {2'b00, cfg.window_longest_ms};
              st_q   <= S_WIN;
            end
          end
        end
        S_WIN: begin
          if (!win_ok || (hand_q && gest_q != GestNone)) st_q <= S_HAND;
          else begin
            idx_q <= '0; found_q <= 1'b0; first_q <= 1'b1; ok_q <= 1'b1;
            f_q <= '0; e_q <= '0;
            st_q <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          // locate first and last selected points
          if (idx_q != cur_cnt) idx_q <= idx_q + CW'(1);
          if (rd_v_q && in_span) begin
            if (!found_q) begin
              fx_q <= rd_x; fy_q <= rd_y; f_q <= rd_pos_q;
            end else first_q <= 1'b0;
            found_q <= 1'b1;
            ex_q <= rd_x; ey_q <= rd_y; e_q <= rd_pos_q;
          end
          if (idx_q == cur_cnt && !rd_v_q) st_q <= S_CHK;
        end
        S_CHK: begin
          if (!found_q || first_q
              || travel <= $signed(VW'(cfg.min_swipe_length))
              || hchg_abs >= VW'(cfg.max_height_change)
              || sum2 < hip2 || sum2 > sh2) begin
            st_q <= S_NEXT;
          end else begin
            idx_q <= f_q; px_q <= fx_q;
            st_q  <= S_SCAN2;
          end
        end
        S_SCAN2: begin
          // neighbor steps and deviation over selected points after first
          if (idx_q != e_q + CW'(1)) idx_q <= idx_q + CW'(1);
          if (rd_v_q && in_span && rd_pos_q != f_q) begin
            px_q <= rd_x;
            if (back > $signed(VW'(cfg.back_step_tolerance))
                || dev_abs > (VW'(cfg.max_dev_from_mean) << 1)) ok_q <= 1'b0;
          end
          if (idx_q == e_q + CW'(1) && !rd_v_q) begin
            if (ok_q && !(rd_v_q && in_span)) begin
              gest_q <= hand_q ? GestRight : GestLeft;
              cnt_q[0] <= '0; cnt_q[1] <= '0;
              hold_q <= 1'b1;
              hold_until_q <= now_q + {16'd0, cfg.hold_off_ms};
              st_q <= S_HAND;
            end else st_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          span_q <= span_q - StepC;
          st_q   <= S_WIN;
        end
        S_HAND: begin
          if (!hand_q) begin
            hand_q <= 1'b1;
            st_q   <= S_PUSH;
          end else st_q <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            st_q     <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid) else $error("ready while result pending");
  a_supp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.suppressed |-> out_if.gesture == GestNone && !out_if.standing)
    else $error("suppressed word carries data");
  a_gest_standing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.gesture != GestNone |-> out_if.standing && hold_q)
    else $error("gesture without standing or hold-off");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= DepthC && cnt_q[1] <= DepthC) else $error("history overflow");
endmodule
